// ----- rtl/core/tevq_pkg.sv -----
// Timed event and ramp queue: shared types and constants.
// No dependencies; used by the interfaces, the slot cells and the top level.
package tevq_pkg;

  localparam int FRAME_W  = 48;
  localparam int ID_W     = 16;
  localparam int STEP_W   = 16;
  localparam int SF_W     = 32;
  localparam int PC_W     = 5;
  localparam int EV_IDX_W = 8;   // enough for the largest event table
  localparam int RP_IDX_W = 6;   // enough for the largest ramp table

  localparam logic [2:0] CMD_SCHED      = 3'd0;
  localparam logic [2:0] CMD_RAMP       = 3'd1;
  localparam logic [2:0] CMD_CANCEL     = 3'd2;
  localparam logic [2:0] CMD_CANCEL_ALL = 3'd3;
  localparam logic [2:0] CMD_TICK       = 3'd4;
  localparam logic [2:0] CMD_QUERY      = 3'd5;

  localparam logic [2:0] KIND_ACK   = 3'd0;
  localparam logic [2:0] KIND_FIRE  = 3'd1;
  localparam logic [2:0] KIND_STEP  = 3'd2;
  localparam logic [2:0] KIND_DONE  = 3'd3;
  localparam logic [2:0] KIND_QUERY = 3'd4;
  localparam logic [2:0] KIND_FULL  = 3'd5;
  localparam logic [2:0] KIND_NONE  = 3'd6;

  localparam logic [FRAME_W-1:0] FRAME_MAX = {FRAME_W{1'b1}};

  typedef struct packed {
    logic                hit;
    logic                cxl;
    logic [FRAME_W-1:0]  target;
    logic [ID_W-1:0]     tag;
    logic [EV_IDX_W-1:0] idx;
  } ev_cand_t;

  typedef struct packed {
    logic wr;
    logic clr;
    logic cxl;
  } ev_ctl_t;

  typedef struct packed {
    logic                hit;
    logic                cxl;
    logic [ID_W-1:0]     tag;
    logic [RP_IDX_W-1:0] idx;
  } rp_cand_t;

  typedef struct packed {
    logic wr;
    logic clr;
    logic cxl;
    logic step;
  } rp_ctl_t;

  typedef struct packed {
    logic [2:0]        kind;
    logic [ID_W-1:0]   id;
    logic [STEP_W-1:0] step;
  } res_t;

endpackage

// ----- rtl/core/tevq_if.sv -----
// Request and result channel interfaces for the timed event and ramp queue.
// Depends on tevq_pkg for field widths.
interface tevq_in_if;
  logic                         valid;
  logic                         ready;
  logic [2:0]                   command;
  logic [tevq_pkg::FRAME_W-1:0] frame;
  logic [tevq_pkg::FRAME_W-1:0] now_frame;
  logic [tevq_pkg::SF_W-1:0]    step_frames;
  logic [tevq_pkg::STEP_W-1:0]  step_count;
  logic [tevq_pkg::ID_W-1:0]    item_id;

  modport source (output valid, command, frame, now_frame, step_frames, step_count,
                  item_id, input ready);
  modport sink (input valid, command, frame, now_frame, step_frames, step_count,
                item_id, output ready);
endinterface

interface tevq_out_if;
  logic                         valid;
  logic                         ready;
  logic [2:0]                   kind;
  logic [tevq_pkg::ID_W-1:0]    result_id;
  logic [tevq_pkg::STEP_W-1:0]  step_index;
  logic                         is_pending;
  logic                         target_valid;
  logic [tevq_pkg::FRAME_W-1:0] target_frame;
  logic [tevq_pkg::PC_W-1:0]    pending_count;
  logic                         last;

  modport source (output valid, kind, result_id, step_index, is_pending, target_valid,
                  target_frame, pending_count, last, input ready);
  modport sink (input valid, kind, result_id, step_index, is_pending, target_valid,
                target_frame, pending_count, last, output ready);
endinterface

// ----- rtl/core/tevq_ev_cell.sv -----
// One event slot of the chain: holds target, id and flags, and forwards
// the earliest due candidate seen so far to its neighbor. Uses tevq_pkg.
module tevq_ev_cell (
  input  logic                              clk,
  input  logic                              rst_n,
  input  tevq_pkg::ev_ctl_t                 ctl,
  input  logic [tevq_pkg::FRAME_W-1:0]      wr_target,
  input  logic [tevq_pkg::ID_W-1:0]         wr_tag,
  input  logic [tevq_pkg::FRAME_W-1:0]      now,
  input  logic [tevq_pkg::EV_IDX_W-1:0]     slot_idx,
  input  tevq_pkg::ev_cand_t                cand_i,
  output tevq_pkg::ev_cand_t                cand_o,
  output logic                              valid_o,
  output logic                              cxl_o,
  output logic [tevq_pkg::ID_W-1:0]         tag_o,
  output logic [tevq_pkg::FRAME_W-1:0]      target_o
);
  logic                         valid_r;
  logic                         cxl_r;
  logic [tevq_pkg::FRAME_W-1:0] target_r;
  logic [tevq_pkg::ID_W-1:0]    tag_r;
  tevq_pkg::ev_cand_t           cand_r;
  tevq_pkg::ev_cand_t           cand_nxt;
  logic                         due;
  logic                         take;

  // Strict compares: on equal targets the lower tag wins; on a full tie the lower slot upstream keeps the candidate.
  always_comb begin
    due  = valid_r && (target_r <= now);
    take = due && (!cand_i.hit || (target_r < cand_i.target) ||
                   ((target_r == cand_i.target) && (tag_r < cand_i.tag)));
    if (take) begin
      cand_nxt.hit    = 1'b1;
      cand_nxt.cxl    = cxl_r;
      cand_nxt.target = target_r;
      cand_nxt.tag    = tag_r;
      cand_nxt.idx    = slot_idx;
    end else begin
      cand_nxt = cand_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      cxl_r   <= 1'b0;
      cand_r  <= '0;
    end else begin
      cand_r <= cand_nxt;
      if (ctl.clr) begin
        valid_r <= 1'b0;
        cxl_r   <= 1'b0;
      end else if (ctl.wr) begin
        valid_r <= 1'b1;
        cxl_r   <= 1'b0;
      end else if (ctl.cxl) begin
        cxl_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      target_r <= wr_target;
      tag_r    <= wr_tag;
    end
  end

  assign cand_o   = cand_r;
  assign valid_o  = valid_r;
  assign cxl_o    = cxl_r;
  assign tag_o    = tag_r;
  assign target_o = target_r;
endmodule

// ----- rtl/core/tevq_rp_cell.sv -----
// One ramp slot of the chain: holds the ramp state, advances it a step on
// request and forwards the lowest-id unvisited ramp. Uses tevq_pkg.
module tevq_rp_cell (
  input  logic                              clk,
  input  logic                              rst_n,
  input  tevq_pkg::rp_ctl_t                 ctl,
  input  logic [tevq_pkg::FRAME_W-1:0]      wr_origin,
  input  logic [tevq_pkg::SF_W-1:0]         wr_interval,
  input  logic [tevq_pkg::STEP_W-1:0]       wr_total,
  input  logic [tevq_pkg::ID_W-1:0]         wr_tag,
  input  logic                              seen_i,
  input  logic [tevq_pkg::RP_IDX_W-1:0]     slot_idx,
  input  tevq_pkg::rp_cand_t                cand_i,
  output tevq_pkg::rp_cand_t                cand_o,
  output logic                              valid_o,
  output logic [tevq_pkg::ID_W-1:0]         tag_o,
  output logic [tevq_pkg::FRAME_W-1:0]      next_o,
  output logic [tevq_pkg::STEP_W-1:0]       total_o,
  output logic [tevq_pkg::STEP_W-1:0]       done_o
);
  logic                         valid_r;
  logic                         cxl_r;
  logic [tevq_pkg::FRAME_W-1:0] next_r;
  logic [tevq_pkg::SF_W-1:0]    interval_r;
  logic [tevq_pkg::STEP_W-1:0]  total_r;
  logic [tevq_pkg::STEP_W-1:0]  done_r;
  logic [tevq_pkg::ID_W-1:0]    tag_r;
  tevq_pkg::rp_cand_t           cand_r;
  tevq_pkg::rp_cand_t           cand_nxt;
  logic [tevq_pkg::FRAME_W:0]   sum;
  logic [tevq_pkg::FRAME_W-1:0] next_nxt;
  logic                         take;

  always_comb begin
    sum      = {1'b0, next_r} + {{(tevq_pkg::FRAME_W + 1 - tevq_pkg::SF_W){1'b0}}, interval_r};
    next_nxt = sum[tevq_pkg::FRAME_W] ? tevq_pkg::FRAME_MAX : sum[tevq_pkg::FRAME_W-1:0];
    take     = valid_r && !seen_i && (!cand_i.hit || (tag_r < cand_i.tag));
    if (take) begin
      cand_nxt.hit = 1'b1;
      cand_nxt.cxl = cxl_r;
      cand_nxt.tag = tag_r;
      cand_nxt.idx = slot_idx;
    end else begin
      cand_nxt = cand_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      cxl_r   <= 1'b0;
      cand_r  <= '0;
    end else begin
      cand_r <= cand_nxt;
      if (ctl.clr) begin
        valid_r <= 1'b0;
        cxl_r   <= 1'b0;
      end else if (ctl.wr) begin
        valid_r <= 1'b1;
        cxl_r   <= 1'b0;
      end else if (ctl.cxl) begin
        cxl_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      next_r     <= wr_origin;
      interval_r <= wr_interval;
      total_r    <= wr_total;
      done_r     <= '0;
      tag_r      <= wr_tag;
    end else if (ctl.step) begin
      next_r <= next_nxt;
      done_r <= done_r + 1'b1;
    end
  end

  assign cand_o  = cand_r;
  assign valid_o = valid_r;
  assign tag_o   = tag_r;
  assign next_o  = next_r;
  assign total_o = total_r;
  assign done_o  = done_r;
endmodule

// ----- rtl/core/timed_event_and_ramp_queue.sv -----
// Timed event and ramp queue, top level. A non-tick request gives one result. Tick:
// each event pick waits for the candidate to pass through the event chain, each
// ramp pick through the ramp chain, and ramp steps follow; results are then read
// from a buffer one at a time on the output handshake. One request at a time.
// Reset (synchronous, rst_n low) empties all slots and zeroes the id counter.
// Depends on tevq_pkg, tevq_if, tevq_ev_cell and tevq_rp_cell.
module timed_event_and_ramp_queue #(
  parameter int EVENT_SLOTS          = 16,
  parameter int RAMP_SLOTS           = 4,
  parameter int MAX_RESULTS_PER_TICK = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  tevq_in_if.sink     in_chan,
  tevq_out_if.source  out_chan
);
  localparam int EIW = (EVENT_SLOTS > 1) ? $clog2(EVENT_SLOTS) : 1;
  localparam int RIW = (RAMP_SLOTS > 1) ? $clog2(RAMP_SLOTS) : 1;
  localparam int NW  = $clog2(MAX_RESULTS_PER_TICK + 1);
  localparam int BAW = $clog2(MAX_RESULTS_PER_TICK);
  localparam int PCW = $clog2(EVENT_SLOTS + RAMP_SLOTS + 1);
  localparam int WW  = $clog2(EVENT_SLOTS + RAMP_SLOTS);
  localparam int FW  = tevq_pkg::FRAME_W;
  localparam int IDW = tevq_pkg::ID_W;

  typedef enum logic [10:0] {
    S_IDLE    = 11'b00000000001,
    S_EXEC    = 11'b00000000010,
    S_EV_WAIT = 11'b00000000100,
    S_EV_TAKE = 11'b00000001000,
    S_RP_WAIT = 11'b00000010000,
    S_RP_TAKE = 11'b00000100000,
    S_RP_STEP = 11'b00001000000,
    S_FINISH  = 11'b00010000000,
    S_READ    = 11'b00100000000,
    S_LOAD    = 11'b01000000000,
    S_SEND    = 11'b10000000000
  } state_t;

  state_t state_r, state_nxt;
  logic [2:0]                  cmd_r;
  logic [FW-1:0]               frame_r, now_r;
  logic [tevq_pkg::SF_W-1:0]   sf_r;
  logic [tevq_pkg::STEP_W-1:0] sc_r;
  logic [IDW-1:0]              id_r;
  logic [IDW-1:0]              next_tag_r, next_tag_nxt;
  logic [PCW-1:0]              pc_r, pc_nxt;
  logic [NW-1:0]               n_r, n_nxt;
  logic [NW-1:0]               rd_r, rd_nxt;
  logic [WW-1:0]               wcnt_r, wcnt_nxt;
  logic [RAMP_SLOTS-1:0]       seen_r, seen_nxt;
  logic [RIW-1:0]              rsel_r, rsel_nxt;
  logic                        q_pend_r, q_pend_nxt, q_tv_r, q_tv_nxt;
  logic [FW-1:0]               q_tf_r, q_tf_nxt;

  tevq_pkg::res_t              res_mem [MAX_RESULTS_PER_TICK];
  tevq_pkg::res_t              buf_q;
  tevq_pkg::res_t              push_data;
  logic                        push_en, rd_en;

  logic                        out_valid_r, out_valid_nxt;
  logic [2:0]                  out_kind_r;
  logic [IDW-1:0]              out_id_r;
  logic [tevq_pkg::STEP_W-1:0] out_step_r;
  logic                        out_pend_r, out_tv_r, out_last_r;
  logic [FW-1:0]               out_tf_r;
  logic [tevq_pkg::PC_W-1:0]   out_pc_r;
  logic                        load_en;

  tevq_pkg::ev_ctl_t           ev_ctl   [EVENT_SLOTS];
  tevq_pkg::ev_cand_t          ev_chain [EVENT_SLOTS+1];
  logic [EVENT_SLOTS-1:0]      ev_valid, ev_cxl, ev_match;
  logic [IDW-1:0]              ev_tag    [EVENT_SLOTS];
  logic [FW-1:0]               ev_target [EVENT_SLOTS];

  tevq_pkg::rp_ctl_t           rp_ctl   [RAMP_SLOTS];
  tevq_pkg::rp_cand_t          rp_chain [RAMP_SLOTS+1];
  logic [RAMP_SLOTS-1:0]       rp_valid, rp_match;
  logic [IDW-1:0]              rp_tag   [RAMP_SLOTS];
  logic [FW-1:0]               rp_next  [RAMP_SLOTS];
  logic [tevq_pkg::STEP_W-1:0] rp_total [RAMP_SLOTS];
  logic [tevq_pkg::STEP_W-1:0] rp_done  [RAMP_SLOTS];
  logic [tevq_pkg::SF_W-1:0]   sf_eff;

  assign ev_chain[0] = '0;
  assign rp_chain[0] = '0;
  assign sf_eff      = (sf_r == '0) ? tevq_pkg::SF_W'(1) : sf_r;

  for (genvar g = 0; g < EVENT_SLOTS; g++) begin : g_ev
    tevq_ev_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ev_ctl[g]),
      .wr_target (frame_r),
      .wr_tag    (next_tag_r),
      .now       (now_r),
      .slot_idx  (tevq_pkg::EV_IDX_W'(g)),
      .cand_i    (ev_chain[g]),
      .cand_o    (ev_chain[g+1]),
      .valid_o   (ev_valid[g]),
      .cxl_o     (ev_cxl[g]),
      .tag_o     (ev_tag[g]),
      .target_o  (ev_target[g])
    );
    assign ev_match[g] = ev_valid[g] && (ev_tag[g] == id_r);
  end

  for (genvar g = 0; g < RAMP_SLOTS; g++) begin : g_rp
    tevq_rp_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctl         (rp_ctl[g]),
      .wr_origin   (frame_r),
      .wr_interval (sf_eff),
      .wr_total    (sc_r),
      .wr_tag      (next_tag_r),
      .seen_i      (seen_r[g]),
      .slot_idx    (tevq_pkg::RP_IDX_W'(g)),
      .cand_i      (rp_chain[g]),
      .cand_o      (rp_chain[g+1]),
      .valid_o     (rp_valid[g]),
      .tag_o       (rp_tag[g]),
      .next_o      (rp_next[g]),
      .total_o     (rp_total[g]),
      .done_o      (rp_done[g])
    );
    assign rp_match[g] = rp_valid[g] && (rp_tag[g] == id_r);
  end

  logic               ev_free, ev_hit, rp_free, rp_hit;
  logic [EIW-1:0]     ev_free_idx, ev_hit_idx;
  logic [RIW-1:0]     rp_free_idx, rp_hit_idx;
  tevq_pkg::ev_cand_t ev_tail;
  tevq_pkg::rp_cand_t rp_tail;
  logic               r_due, r_complete, budget_full;

  assign ev_tail     = ev_chain[EVENT_SLOTS];
  assign rp_tail     = rp_chain[RAMP_SLOTS];
  assign budget_full = (n_r == NW'(MAX_RESULTS_PER_TICK));
  assign r_complete  = (rp_done[rsel_r] >= rp_total[rsel_r]);
  assign r_due       = !r_complete && (rp_next[rsel_r] <= now_r);

  // Lowest free and lowest matching slots.
  always_comb begin
    ev_free = 1'b0; ev_free_idx = '0; ev_hit = 1'b0; ev_hit_idx = '0;
    rp_free = 1'b0; rp_free_idx = '0; rp_hit = 1'b0; rp_hit_idx = '0;
    for (int i = EVENT_SLOTS - 1; i >= 0; i--) begin
      if (!ev_valid[i]) begin
        ev_free = 1'b1; ev_free_idx = EIW'(i);
      end
      if (ev_match[i]) begin
        ev_hit = 1'b1; ev_hit_idx = EIW'(i);
      end
    end
    for (int i = RAMP_SLOTS - 1; i >= 0; i--) begin
      if (!rp_valid[i]) begin
        rp_free = 1'b1; rp_free_idx = RIW'(i);
      end
      if (rp_match[i]) begin
        rp_hit = 1'b1; rp_hit_idx = RIW'(i);
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    next_tag_nxt  = next_tag_r;
    pc_nxt        = pc_r;
    n_nxt         = n_r;
    rd_nxt        = rd_r;
    wcnt_nxt      = wcnt_r;
    seen_nxt      = seen_r;
    rsel_nxt      = rsel_r;
    q_pend_nxt    = q_pend_r;
    q_tv_nxt      = q_tv_r;
    q_tf_nxt      = q_tf_r;
    out_valid_nxt = out_valid_r;
    push_en       = 1'b0;
    push_data     = '0;
    rd_en         = 1'b0;
    load_en       = 1'b0;
    for (int i = 0; i < EVENT_SLOTS; i++) ev_ctl[i] = '0;
    for (int i = 0; i < RAMP_SLOTS; i++) rp_ctl[i] = '0;
    if (push_en) n_nxt = n_r;

    unique case (state_r)
      S_IDLE: begin
        n_nxt = '0;
        if (in_chan.valid) begin
          if (in_chan.command <= tevq_pkg::CMD_QUERY) state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_FINISH;
        push_en   = 1'b1;
        if (cmd_r == tevq_pkg::CMD_SCHED) begin
          if (ev_free) begin
            ev_ctl[ev_free_idx].wr = 1'b1;
            push_data    = '{kind: tevq_pkg::KIND_ACK, id: next_tag_r, step: '0};
            next_tag_nxt = next_tag_r + 1'b1;
            pc_nxt       = pc_r + 1'b1;
          end else begin
            push_data = '{kind: tevq_pkg::KIND_FULL, id: '0, step: '0};
          end
        end else if (cmd_r == tevq_pkg::CMD_RAMP) begin
          if (rp_free) begin
            rp_ctl[rp_free_idx].wr = 1'b1;
            push_data    = '{kind: tevq_pkg::KIND_ACK, id: next_tag_r, step: '0};
            next_tag_nxt = next_tag_r + 1'b1;
            pc_nxt       = pc_r + 1'b1;
          end else begin
            push_data = '{kind: tevq_pkg::KIND_FULL, id: '0, step: '0};
          end
        end else if (cmd_r == tevq_pkg::CMD_CANCEL) begin
          if (ev_hit) ev_ctl[ev_hit_idx].cxl = 1'b1;
          else if (rp_hit) rp_ctl[rp_hit_idx].cxl = 1'b1;
          push_data = '{kind: tevq_pkg::KIND_ACK, id: id_r, step: '0};
        end else if (cmd_r == tevq_pkg::CMD_CANCEL_ALL) begin
          for (int i = 0; i < EVENT_SLOTS; i++) ev_ctl[i].clr = 1'b1;
          for (int i = 0; i < RAMP_SLOTS; i++) rp_ctl[i].clr = 1'b1;
          pc_nxt    = '0;
          push_data = '{kind: tevq_pkg::KIND_ACK, id: '0, step: '0};
        end else if (cmd_r == tevq_pkg::CMD_QUERY) begin
          q_pend_nxt = (|(ev_match & ~ev_cxl)) || (|rp_match);
          q_tv_nxt   = ev_hit;
          q_tf_nxt   = ev_hit ? ev_target[ev_hit_idx] : '0;
          push_data  = '{kind: tevq_pkg::KIND_QUERY, id: id_r, step: '0};
        end else begin
          // tick: start the first event pick
          push_en   = 1'b0;
          wcnt_nxt  = '0;
          state_nxt = S_EV_WAIT;
        end
      end
      S_EV_WAIT: begin
        if (wcnt_r == WW'(EVENT_SLOTS - 1)) state_nxt = S_EV_TAKE;
        else wcnt_nxt = wcnt_r + 1'b1;
      end
      S_EV_TAKE: begin
        wcnt_nxt = '0;
        if (budget_full || !ev_tail.hit) begin
          seen_nxt  = '0;
          state_nxt = S_RP_WAIT;
        end else begin
          // cancelled events leave silently
          if (!ev_tail.cxl) begin
            push_en   = 1'b1;
            push_data = '{kind: tevq_pkg::KIND_FIRE, id: ev_tail.tag, step: '0};
          end
          ev_ctl[ev_tail.idx[EIW-1:0]].clr = 1'b1;
          pc_nxt    = pc_r - 1'b1;
          state_nxt = S_EV_WAIT;
        end
      end
      S_RP_WAIT: begin
        if (wcnt_r == WW'(RAMP_SLOTS - 1)) state_nxt = S_RP_TAKE;
        else wcnt_nxt = wcnt_r + 1'b1;
      end
      S_RP_TAKE: begin
        wcnt_nxt = '0;
        if (!rp_tail.hit) begin
          state_nxt = S_FINISH;
        end else begin
          seen_nxt[rp_tail.idx[RIW-1:0]] = 1'b1;
          if (rp_tail.cxl) begin
            rp_ctl[rp_tail.idx[RIW-1:0]].clr = 1'b1;
            pc_nxt    = pc_r - 1'b1;
            state_nxt = S_RP_WAIT;
          end else begin
            rsel_nxt  = rp_tail.idx[RIW-1:0];
            state_nxt = S_RP_STEP;
          end
        end
      end
      S_RP_STEP: begin
        wcnt_nxt = '0;
        if (r_due) begin
          if (budget_full) begin
            state_nxt = S_FINISH;
          end else begin
            push_en   = 1'b1;
            push_data = '{kind: tevq_pkg::KIND_STEP, id: rp_tag[rsel_r],
                          step: rp_done[rsel_r]};
            rp_ctl[rsel_r].step = 1'b1;
          end
        end else if (r_complete) begin
          if (budget_full) begin
            state_nxt = S_FINISH;
          end else begin
            push_en   = 1'b1;
            push_data = '{kind: tevq_pkg::KIND_DONE, id: rp_tag[rsel_r], step: '0};
            rp_ctl[rsel_r].clr = 1'b1;
            pc_nxt    = pc_r - 1'b1;
            state_nxt = S_RP_WAIT;
          end
        end else begin
          state_nxt = S_RP_WAIT;
        end
      end
      S_FINISH: begin
        if (n_r == '0) begin
          push_en   = 1'b1;
          push_data = '{kind: tevq_pkg::KIND_NONE, id: '0, step: '0};
        end
        rd_nxt    = '0;
        state_nxt = S_READ;
      end
      S_READ: begin
        if (rd_r == n_r) begin
          state_nxt = S_IDLE;
        end else begin
          rd_en     = 1'b1;
          state_nxt = S_LOAD;
        end
      end
      S_LOAD: begin
        load_en       = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = S_SEND;
      end
      S_SEND: begin
        if (out_chan.ready) begin
          out_valid_nxt = 1'b0;
          rd_nxt        = rd_r + 1'b1;
          state_nxt     = S_READ;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    if (push_en) n_nxt = n_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      next_tag_r  <= '0;
      pc_r        <= '0;
      n_r         <= '0;
      rd_r        <= '0;
      wcnt_r      <= '0;
      seen_r      <= '0;
      rsel_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      next_tag_r  <= next_tag_nxt;
      pc_r        <= pc_nxt;
      n_r         <= n_nxt;
      rd_r        <= rd_nxt;
      wcnt_r      <= wcnt_nxt;
      seen_r      <= seen_nxt;
      rsel_r      <= rsel_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Request capture and query fields.
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_chan.valid) begin
      cmd_r   <= in_chan.command;
      frame_r <= in_chan.frame;
      now_r   <= in_chan.now_frame;
      sf_r    <= in_chan.step_frames;
      sc_r    <= in_chan.step_count;
      id_r    <= in_chan.item_id;
    end
    q_pend_r <= q_pend_nxt;
    q_tv_r   <= q_tv_nxt;
    q_tf_r   <= q_tf_nxt;
  end

  // Result buffer: written during the request, read back once it is complete.
  always_ff @(posedge clk) begin
    if (push_en) res_mem[n_r[BAW-1:0]] <= push_data;
    if (rd_en) buf_q <= res_mem[rd_r[BAW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (load_en) begin
      out_kind_r <= buf_q.kind;
      out_id_r   <= buf_q.id;
      out_step_r <= buf_q.step;
      out_last_r <= (rd_r == n_r - 1'b1);
      out_pc_r   <= (pc_r > PCW'(31)) ? tevq_pkg::PC_W'(31) : tevq_pkg::PC_W'(pc_r);
      if (buf_q.kind == tevq_pkg::KIND_QUERY) begin
        out_pend_r <= q_pend_r;
        out_tv_r   <= q_tv_r;
        out_tf_r   <= q_tf_r;
      end else begin
        out_pend_r <= 1'b0;
        out_tv_r   <= 1'b0;
        out_tf_r   <= '0;
      end
    end
  end

  assign in_chan.ready          = (state_r == S_IDLE);
  assign out_chan.valid         = out_valid_r;
  assign out_chan.kind          = out_kind_r;
  assign out_chan.result_id     = out_id_r;
  assign out_chan.step_index    = out_step_r;
  assign out_chan.is_pending    = out_pend_r;
  assign out_chan.target_valid  = out_tv_r;
  assign out_chan.target_frame  = out_tf_r;
  assign out_chan.pending_count = out_pc_r;
  assign out_chan.last          = out_last_r;
endmodule
